[sv/ucrr_pkg.sv]
// ucrr_pkg: shared types, codes and helpers for the usb control request responder
// used by ucrr_core and usb_control_request_responder_unit; no dependencies
package ucrr_pkg;

	localparam int unsigned PACKET_SIZE = 64;

	// event kinds
	localparam logic [1:0] MODE_SETUP     = 2'd0;
	localparam logic [1:0] MODE_IN_DONE   = 2'd1;
	localparam logic [1:0] MODE_BUS_RESET = 2'd2;

	// result actions
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_DATA = 2'd1;
	localparam logic [1:0] ACT_ZLP  = 2'd2;

	// descriptor sources
	localparam logic [1:0] SRC_DEVICE = 2'd0;
	localparam logic [1:0] SRC_CONFIG = 2'd1;
	localparam logic [1:0] SRC_STRING = 2'd2;
	localparam logic [1:0] SRC_REPORT = 2'd3;

	// bmRequestType type field
	localparam logic [1:0] KIND_STANDARD = 2'd0;
	localparam logic [1:0] KIND_CLASS    = 2'd1;

	// bRequest codes
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_HID_SET_IDLE      = 8'd10;

	// descriptor types
	localparam logic [7:0] DT_DEVICE = 8'h01;
	localparam logic [7:0] DT_CONFIG = 8'h02;
	localparam logic [7:0] DT_STRING = 8'h03;
	localparam logic [7:0] DT_REPORT = 8'h22;

	localparam int unsigned NUM_STRINGS = 4;

	// configuration register indexes
	localparam logic [2:0] REG_DEVICE_DESC_LEN = 3'd0;
	localparam logic [2:0] REG_CONFIG_DESC_LEN = 3'd1;
	localparam logic [2:0] REG_STRING0_LEN     = 3'd2;
	localparam logic [2:0] REG_STRING1_LEN     = 3'd3;
	localparam logic [2:0] REG_STRING2_LEN     = 3'd4;
	localparam logic [2:0] REG_STRING3_LEN     = 3'd5;
	localparam logic [2:0] REG_REPORT_DESC_LEN = 3'd6;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  endpoint;
		logic [7:0]  setup_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_length;
	} ucrr_event_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] source;
		logic [1:0] string_index;
		logic [9:0] byte_offset;
		logic [6:0] send_length;
		logic       address_apply;
		logic [6:0] device_address;
	} ucrr_result_t;

	typedef struct packed {
		logic [6:0]            device_desc_len;
		logic [9:0]            config_desc_len;
		logic [3:0][6:0]       string_len;
		logic [9:0]            report_desc_len;
	} ucrr_cfg_t;

	typedef struct packed {
		logic       addr_pending;
		logic [6:0] pending_addr;
		logic       xfer_active;
		logic [9:0] xfer_total;
		logic [9:0] xfer_sent;
	} ucrr_state_t;

	localparam ucrr_cfg_t CFG_RESET = '{
		device_desc_len: 7'd18,
		config_desc_len: 10'd34,
		string_len:      {7'd0, 7'd0, 7'd0, 7'd4},
		report_desc_len: 10'd0
	};

	// saturate a byte count to one packet
	function automatic logic [6:0] clip_packet(input logic [9:0] n);
		logic [6:0] r;
		r = (n > 10'(PACKET_SIZE)) ? 7'(PACKET_SIZE) : n[6:0];
		return r;
	endfunction

endpackage

[sv/ucrr_core.sv]
// ucrr_core: single-pass decode of one device event against the current state
// depends on ucrr_pkg
module ucrr_core import ucrr_pkg::*; (
	input  ucrr_event_t  ev,
	input  ucrr_state_t  st,
	input  ucrr_cfg_t    cfg,
	output ucrr_result_t res,
	output ucrr_state_t  st_next
);

	logic [1:0]  kind;
	logic [7:0]  dtype;
	logic [7:0]  str_idx;
	logic [9:0]  cfg_min;
	logic [6:0]  rpt_first;
	logic [9:0]  remain;
	logic [6:0]  chunk;
	logic        sent_aligned;

	assign kind    = ev.setup_type[6:5];
	assign dtype   = ev.request_value[15:8];
	assign str_idx = ev.request_value[7:0];
	// configuration descriptor is clipped to wLength before packet saturation
	assign cfg_min = ({6'd0, cfg.config_desc_len} < ev.request_length)
		? cfg.config_desc_len : ev.request_length[9:0];
	assign rpt_first    = clip_packet(cfg.report_desc_len);
	assign remain       = st.xfer_total - st.xfer_sent;
	assign chunk        = clip_packet(remain);
	assign sent_aligned = (st.xfer_sent % 10'(PACKET_SIZE)) == 10'd0;

	always_comb begin
		res     = '0;
		st_next = st;
		unique case (ev.mode)
			MODE_SETUP: begin
				if (ev.endpoint == 3'd0) begin
					st_next.xfer_active = 1'b0;
					if (ev.setup_type[7]) begin
						if (kind == KIND_STANDARD && ev.request_code == REQ_GET_DESCRIPTOR) begin
							unique case (dtype)
								DT_DEVICE: begin
									res.action      = ACT_DATA;
									res.source      = SRC_DEVICE;
									res.send_length = clip_packet({3'd0, cfg.device_desc_len});
								end
								DT_CONFIG: begin
									res.action      = ACT_DATA;
									res.source      = SRC_CONFIG;
									res.send_length = clip_packet(cfg_min);
								end
								DT_STRING: begin
									if (str_idx < 8'(NUM_STRINGS)) begin
										res.action       = ACT_DATA;
										res.source       = SRC_STRING;
										res.string_index = str_idx[1:0];
										res.send_length  =
											clip_packet({3'd0, cfg.string_len[str_idx[1:0]]});
									end
								end
								DT_REPORT: begin
									res.action          = ACT_DATA;
									res.source          = SRC_REPORT;
									res.send_length     = rpt_first;
									st_next.xfer_total  = cfg.report_desc_len;
									st_next.xfer_sent   = {3'd0, rpt_first};
									st_next.xfer_active = 1'b1;
								end
								default: ;
							endcase
						end
					end else begin
						if (kind == KIND_STANDARD && ev.request_code == REQ_SET_ADDRESS) begin
							st_next.addr_pending = 1'b1;
							st_next.pending_addr = ev.request_value[6:0];
							res.action           = ACT_ZLP;
						end else if (kind == KIND_STANDARD &&
							ev.request_code == REQ_SET_CONFIGURATION) begin
							res.action = ACT_ZLP;
						end else if (kind == KIND_CLASS && ev.request_code == REQ_HID_SET_IDLE) begin
							res.action = ACT_ZLP;
						end
					end
				end
			end
			MODE_IN_DONE: begin
				// latched address takes effect on any endpoint
				if (st.addr_pending) begin
					res.address_apply    = 1'b1;
					res.device_address   = st.pending_addr;
					st_next.addr_pending = 1'b0;
				end
				if (ev.endpoint == 3'd0 && st.xfer_active) begin
					if (st.xfer_sent < st.xfer_total) begin
						res.action        = ACT_DATA;
						res.source        = SRC_REPORT;
						res.byte_offset   = st.xfer_sent;
						res.send_length   = chunk;
						st_next.xfer_sent = st.xfer_sent + {3'd0, chunk};
					end else if (st.xfer_sent != 10'd0 && sent_aligned) begin
						// closing zero-length packet
						res.action          = ACT_ZLP;
						st_next.xfer_active = 1'b0;
					end else begin
						st_next.xfer_active = 1'b0;
					end
				end
			end
			MODE_BUS_RESET: begin
				st_next            = '0;
				res.address_apply  = 1'b1;
				res.device_address = 7'd0;
			end
			default: ;
		endcase
	end

endmodule

[sv/usb_control_request_responder_unit.sv]
// usb_control_request_responder_unit: top level, event and result registers,
// request state and length registers; depends on ucrr_pkg and ucrr_core
//
// Takes one device event per cycle while not stalled and returns exactly one
// result per event. Each event passes an input register, is decoded
// combinationally by ucrr_core against the request state, and lands in the
// result register. A stalled result holds the event register, which then
// stalls the event channel. Length registers are written through the cfg
// port, always ready, and should only change when no event is in flight.
// No clearing pass after reset.
module usb_control_request_responder_unit import ucrr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         event_valid,
	output logic         event_stall,
	input  ucrr_event_t  event_data,
	output logic         result_valid,
	input  logic         result_stall,
	output ucrr_result_t result_data,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [9:0]   cfg_wdata
);

	ucrr_event_t  ev_s1;
	logic         ev_valid_s1;
	ucrr_result_t res_s2;
	logic         res_valid_s2;
	ucrr_cfg_t    cfg_q;
	ucrr_state_t  state_q;
	ucrr_state_t  state_next;
	ucrr_result_t res_next;
	logic         advance;
	logic         ev_accept;

	assign advance     = ev_valid_s1 && (!res_valid_s2 || !result_stall);
	assign event_stall = ev_valid_s1 && !advance;
	assign ev_accept   = event_valid && !event_stall;
	assign cfg_ready   = 1'b1;

	ucrr_core u_core (
		.ev      (ev_s1),
		.st      (state_q),
		.cfg     (cfg_q),
		.res     (res_next),
		.st_next (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
		end else if (ev_accept) begin
			ev_valid_s1 <= 1'b1;
		end else if (advance) begin
			ev_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_accept) begin
			ev_s1 <= event_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	// request state moves with each decoded event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEVICE_DESC_LEN: cfg_q.device_desc_len <= cfg_wdata[6:0];
				REG_CONFIG_DESC_LEN: cfg_q.config_desc_len <= cfg_wdata;
				REG_STRING0_LEN:     cfg_q.string_len[0]   <= cfg_wdata[6:0];
				REG_STRING1_LEN:     cfg_q.string_len[1]   <= cfg_wdata[6:0];
				REG_STRING2_LEN:     cfg_q.string_len[2]   <= cfg_wdata[6:0];
				REG_STRING3_LEN:     cfg_q.string_len[3]   <= cfg_wdata[6:0];
				REG_REPORT_DESC_LEN: cfg_q.report_desc_len <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign result_valid = res_valid_s2;
	assign result_data  = res_s2;

`ifndef SYNTHESIS
	a_sent_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.xfer_sent <= state_q.xfer_total)
		else $error("report transfer sent count passed its total");

	a_bus_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ev_s1.mode == MODE_BUS_RESET |=>
			!state_q.addr_pending && !state_q.xfer_active && res_s2.address_apply)
		else $error("bus reset did not clear request state");

	a_no_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.action != ACT_DATA |->
			res_s2.send_length == 7'd0 && res_s2.byte_offset == 10'd0)
		else $error("data fields set on a result with no data packet");

	a_len_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> res_s2.send_length <= 7'(PACKET_SIZE))
		else $error("send length above packet size");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		event_stall |-> ev_valid_s1 && res_valid_s2 && result_stall)
		else $error("event channel stalled with room in the pipe");
`endif

endmodule

[dv/usb_control_request_responder_unit_test.sv]
// usb_control_request_responder_unit_test: self-checking bench for the usb control
// request responder, with its own response predictor, randomized traffic and flow control
// depends on ucrr_pkg and usb_control_request_responder_unit
module usb_control_request_responder_unit_test import ucrr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         event_valid = 1'b0;
	logic         event_stall;
	ucrr_event_t  event_data = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	ucrr_result_t result_data;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [9:0]   cfg_wdata = '0;

	usb_control_request_responder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_data(event_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	localparam int STUCK_LIMIT = 2000;

	// length registers as the device sees them
	logic [6:0] dev_len;
	logic [9:0] conf_len;
	logic [6:0] str_len [NUM_STRINGS];
	logic [9:0] rpt_len;

	// request state
	logic       addr_wait;
	logic [6:0] addr_latched;
	logic       rpt_busy;
	logic [9:0] rpt_total;
	logic [9:0] rpt_done;

	ucrr_event_t  host_events [$];
	ucrr_result_t awaited_responses [$];

	int mismatches = 0;
	int stuck_cycles = 0;
	bit running = 1'b0;
	bit quiet = 1'b0;
	bit ev_fire = 1'b0;
	int ev_gap = 0;
	int stall_gap = 0;
	int event_odds = 0;
	int stall_odds = 0;

	function automatic logic [6:0] packet_bytes(input int n);
		return (n > PACKET_SIZE) ? 7'(PACKET_SIZE) : 7'(n);
	endfunction

	// expected answer to one device event; advances the request state
	function automatic ucrr_result_t control_response(input ucrr_event_t ev);
		ucrr_result_t r;
		logic [1:0] kind;
		logic [7:0] dtype;
		logic [7:0] idx;
		logic [6:0] len;
		int n;
		r = '0;
		kind = ev.setup_type[6:5];
		dtype = ev.request_value[15:8];
		idx = ev.request_value[7:0];
		case (ev.mode)
			MODE_SETUP: begin
				if (ev.endpoint == 3'd0) begin
					rpt_busy = 1'b0;
					if (ev.setup_type[7]) begin
						if (kind == KIND_STANDARD && ev.request_code == REQ_GET_DESCRIPTOR) begin
							if (dtype == DT_DEVICE) begin
								r.action = ACT_DATA;
								r.source = SRC_DEVICE;
								r.send_length = packet_bytes(dev_len);
							end else if (dtype == DT_CONFIG) begin
								n = (conf_len < ev.request_length) ? conf_len : ev.request_length;
								r.action = ACT_DATA;
								r.source = SRC_CONFIG;
								r.send_length = packet_bytes(n);
							end else if (dtype == DT_STRING) begin
								if (idx < NUM_STRINGS) begin
									r.action = ACT_DATA;
									r.source = SRC_STRING;
									r.string_index = idx[1:0];
									r.send_length = packet_bytes(str_len[idx[1:0]]);
								end
							end else if (dtype == DT_REPORT) begin
								rpt_total = rpt_len;
								len = packet_bytes(rpt_total);
								rpt_done = 10'(len);
								rpt_busy = 1'b1;
								r.action = ACT_DATA;
								r.source = SRC_REPORT;
								r.send_length = len;
							end
						end
					end else if (kind == KIND_STANDARD && ev.request_code == REQ_SET_ADDRESS) begin
						addr_wait = 1'b1;
						addr_latched = ev.request_value[6:0];
						r.action = ACT_ZLP;
					end else if (kind == KIND_STANDARD && ev.request_code == REQ_SET_CONFIGURATION) begin
						r.action = ACT_ZLP;
					end else if (kind == KIND_CLASS && ev.request_code == REQ_HID_SET_IDLE) begin
						r.action = ACT_ZLP;
					end
				end
			end
			MODE_IN_DONE: begin
				// address takes effect on any endpoint, the report only continues on ep0
				if (addr_wait) begin
					r.address_apply = 1'b1;
					r.device_address = addr_latched;
					addr_wait = 1'b0;
				end
				if (ev.endpoint == 3'd0 && rpt_busy) begin
					if (rpt_done < rpt_total) begin
						len = packet_bytes(rpt_total - rpt_done);
						r.action = ACT_DATA;
						r.source = SRC_REPORT;
						r.byte_offset = rpt_done;
						r.send_length = len;
						rpt_done = rpt_done + 10'(len);
					end else begin
						// closing zero-length packet when the total filled whole packets
						if (rpt_done != 0 && rpt_done % PACKET_SIZE == 0)
							r.action = ACT_ZLP;
						rpt_busy = 1'b0;
					end
				end
			end
			MODE_BUS_RESET: begin
				addr_wait = 1'b0;
				addr_latched = '0;
				rpt_busy = 1'b0;
				rpt_total = '0;
				rpt_done = '0;
				r.address_apply = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string fname, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// event driver
	always @(negedge clk) begin
		if (running && (!event_valid || ev_fire)) begin
			if (ev_gap > 0) begin
				ev_gap--;
				event_valid <= 1'b0;
			end else if (host_events.size() != 0) begin
				if (!quiet && $urandom_range(99) < event_odds) begin
					ev_gap = $urandom_range(18, 1) - 1;
					event_valid <= 1'b0;
				end else begin
					event_data <= host_events.pop_front();
					event_valid <= 1'b1;
				end
			end else begin
				event_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (stall_gap > 0) begin
			stall_gap--;
			result_stall <= 1'b1;
		end else if (running && !quiet && $urandom_range(99) < stall_odds) begin
			stall_gap = $urandom_range(18, 1) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// monitor, predictor hookup and watchdog
	always @(posedge clk) begin
		ucrr_result_t want;
		bit moved;
		if (arst_n) begin
			ev_fire = event_valid && !event_stall;
			moved = ev_fire || (cfg_valid && cfg_ready);
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				if (awaited_responses.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %p",
						$time, result_data);
					mismatches++;
				end else begin
					want = awaited_responses.pop_front();
					check_field("action", want.action, result_data.action);
					check_field("source", want.source, result_data.source);
					check_field("string_index", want.string_index, result_data.string_index);
					check_field("byte_offset", want.byte_offset, result_data.byte_offset);
					check_field("send_length", want.send_length, result_data.send_length);
					check_field("address_apply", want.address_apply, result_data.address_apply);
					check_field("device_address", want.device_address,
						result_data.device_address);
				end
			end
			if (ev_fire)
				awaited_responses.push_back(control_response(event_data));
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic queue_event(input logic [1:0] m, input logic [2:0] ep, input logic [7:0] rt,
		input logic [7:0] rc, input logic [15:0] v, input logic [15:0] l);
		ucrr_event_t ev;
		ev.mode = m;
		ev.endpoint = ep;
		ev.setup_type = rt;
		ev.request_code = rc;
		ev.request_value = v;
		ev.request_length = l;
		host_events.push_back(ev);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 10'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEVICE_DESC_LEN: dev_len = 7'(val);
			REG_CONFIG_DESC_LEN: conf_len = 10'(val);
			REG_STRING0_LEN:     str_len[0] = 7'(val);
			REG_STRING1_LEN:     str_len[1] = 7'(val);
			REG_STRING2_LEN:     str_len[2] = 7'(val);
			REG_STRING3_LEN:     str_len[3] = 7'(val);
			REG_REPORT_DESC_LEN: rpt_len = 10'(val);
			default: ;
		endcase
	endtask

	task automatic set_lengths(input int dv, input int cv, input int s0, input int s1,
		input int s2, input int s3, input int rv);
		write_reg(REG_DEVICE_DESC_LEN, dv);
		write_reg(REG_CONFIG_DESC_LEN, cv);
		write_reg(REG_STRING0_LEN, s0);
		write_reg(REG_STRING1_LEN, s1);
		write_reg(REG_STRING2_LEN, s2);
		write_reg(REG_STRING3_LEN, s3);
		write_reg(REG_REPORT_DESC_LEN, rv);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (host_events.size() != 0 || event_valid || awaited_responses.size() != 0);
	endtask

	// mostly enumeration-like sequences with random content, some noise
	task automatic random_traffic(input int count);
		int added;
		int k;
		logic [7:0] dt;
		logic [7:0] ix;
		logic [15:0] ln;
		added = 0;
		while (added < count) begin
			case ($urandom_range(9)) inside
				[0:2]: begin
					queue_event(MODE_SETUP, 3'd0, {1'b1, KIND_STANDARD, 5'($urandom)},
						REQ_GET_DESCRIPTOR, {DT_REPORT, 8'($urandom)}, 16'($urandom));
					k = $urandom_range(20, 1);
					repeat (k)
						queue_event(MODE_IN_DONE,
							($urandom_range(9) == 0) ? 3'($urandom) : 3'd0,
							8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
					added += k + 1;
				end
				3: begin
					case ($urandom_range(3))
						0: dt = DT_DEVICE;
						1: dt = DT_CONFIG;
						2: dt = DT_STRING;
						default: dt = 8'($urandom);
					endcase
					ix = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
					case ($urandom_range(3))
						0: ln = 16'd0;
						1: ln = 16'($urandom_range(80));
						2: ln = 16'hFFFF;
						default: ln = 16'($urandom);
					endcase
					queue_event(MODE_SETUP, 3'd0, {1'b1, KIND_STANDARD, 5'($urandom)},
						REQ_GET_DESCRIPTOR, {dt, ix}, ln);
					added++;
				end
				4: begin
					queue_event(MODE_SETUP, 3'd0, {1'b0, KIND_STANDARD, 5'($urandom)},
						REQ_SET_ADDRESS, 16'($urandom), 16'($urandom));
					queue_event(MODE_IN_DONE, 3'($urandom), 8'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom));
					added += 2;
				end
				5: begin
					if ($urandom_range(1))
						queue_event(MODE_SETUP, 3'd0, {1'b0, KIND_STANDARD, 5'($urandom)},
							REQ_SET_CONFIGURATION, 16'($urandom), 16'($urandom));
					else
						queue_event(MODE_SETUP, 3'd0, {1'b0, KIND_CLASS, 5'($urandom)},
							REQ_HID_SET_IDLE, 16'($urandom), 16'($urandom));
					added++;
				end
				6: begin
					queue_event(MODE_BUS_RESET, 3'($urandom), 8'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom));
					added++;
				end
				[7:8]: begin
					queue_event(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom));
					added++;
				end
				default: begin
					queue_event(MODE_IN_DONE, 3'($urandom), 8'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom));
					added++;
				end
			endcase
		end
	endtask

	initial begin
		int rv;
		dev_len = 7'd18;
		conf_len = 10'd34;
		str_len = '{7'd4, 7'd0, 7'd0, 7'd0};
		rpt_len = '0;
		addr_wait = 1'b0;
		addr_latched = '0;
		rpt_busy = 1'b0;
		rpt_total = '0;
		rpt_done = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		running = 1'b1;

		// directed: every request kind and the corner cases
		set_lengths(18, 34, 4, 10, 0, 64, 130);
		event_odds = 20;
		stall_odds = 10;
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'hFFFF);
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'd0);
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'd9);
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'hFF}, 16'hFFFF);
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd0}, 16'd255);
		queue_event(MODE_SETUP, 3'd0, 8'h9F, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd3}, 16'd255);
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd4}, 16'd255);
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, 16'hFFFF, 16'd64);
		queue_event(MODE_SETUP, 3'd0, 8'hC0, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd64);
		// report across three packets, IN on another endpoint in between
		queue_event(MODE_SETUP, 3'd0, 8'h81, REQ_GET_DESCRIPTOR, {DT_REPORT, 8'h00}, 16'd200);
		queue_event(MODE_IN_DONE, 3'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
		queue_event(MODE_IN_DONE, 3'd3, 8'h00, 8'h00, 16'h0000, 16'h0000);
		queue_event(MODE_IN_DONE, 3'd0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		queue_event(MODE_IN_DONE, 3'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
		// address applied at the next IN, whatever its endpoint
		queue_event(MODE_SETUP, 3'd0, 8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF);
		queue_event(MODE_IN_DONE, 3'd7, 8'h00, 8'h00, 16'h0000, 16'h0000);
		queue_event(MODE_SETUP, 3'd0, 8'h00, REQ_SET_CONFIGURATION, 16'h0001, 16'd0);
		queue_event(MODE_SETUP, 3'd0, 8'h21, REQ_HID_SET_IDLE, 16'h0000, 16'd0);
		queue_event(MODE_SETUP, 3'd0, 8'h00, 8'hFF, 16'h0000, 16'd0);
		queue_event(MODE_SETUP, 3'd7, 8'h80, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd64);
		// a new setup cuts a running report transfer short
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_REPORT, 8'h00}, 16'd0);
		queue_event(MODE_SETUP, 3'd0, 8'h00, REQ_SET_CONFIGURATION, 16'h0001, 16'd0);
		queue_event(MODE_IN_DONE, 3'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
		queue_event(MODE_BUS_RESET, 3'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
		queue_event(2'd3, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd64);
		wait_drained();

		// report an exact multiple of the packet size: closing zero-length packet
		set_lengths(64, 1023, 64, 64, 64, 64, 128);
		event_odds = 40;
		stall_odds = 25;
		queue_event(MODE_SETUP, 3'd0, 8'h80, REQ_GET_DESCRIPTOR, {DT_REPORT, 8'h00}, 16'd300);
		repeat (4) queue_event(MODE_IN_DONE, 3'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
		random_traffic(100);
		wait_drained();

		set_lengths(0, 0, 0, 0, 0, 0, 0);
		event_odds = 0;
		stall_odds = 0;
		random_traffic(90);
		wait_drained();

		set_lengths(1, 65, 63, 1, 2, 3, 1023);
		event_odds = 10;
		stall_odds = 5;
		random_traffic(110);
		wait_drained();

		rv = $urandom_range(1) ? $urandom_range(1023) : PACKET_SIZE * $urandom_range(15, 1);
		set_lengths($urandom_range(64), $urandom_range(1023), $urandom_range(64),
			$urandom_range(64), $urandom_range(64), $urandom_range(64), rv);
		event_odds = 25;
		stall_odds = 15;
		random_traffic(70);
		while (host_events.size() != 0) @(negedge clk);
		// full rate to the end
		quiet = 1'b1;
		random_traffic(50);
		wait_drained();

		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
